>>> sv/dlf_pkg.sv
package dlf_pkg;

    localparam int DATA_WIDTH      = 16;
    localparam int DEF_MAX_INPUTS  = 64;
    localparam int DEF_MAX_NEURONS = 16;
    localparam int ACC_W           = 40;
    localparam int SUM_W           = 24;
    localparam int NUM_W           = 26;
    localparam int CFG_W           = 7;
    localparam int NIDX_PORT_W     = 4;
    localparam int FIDX_PORT_W     = 6;
    localparam int EXP_W           = 17;

    typedef enum logic [1:0] {
        MODE_WEIGHT  = 2'd0,
        MODE_BIAS    = 2'd1,
        MODE_FEATURE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_RELU    = 2'd1,
        ACT_SIGMOID = 2'd2,
        ACT_SOFTMAX = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        OP_WEIGHT  = 2'd0,
        OP_BIAS    = 2'd1,
        OP_FEATURE = 2'd2
    } op_t;

    localparam logic [1:0] REG_ACT     = 2'd0;
    localparam logic [1:0] REG_INPUTS  = 2'd1;
    localparam logic [1:0] REG_NEURONS = 2'd2;

    typedef struct packed {
        op_t                     op;
        logic                    wr;
        logic                    last;
        logic [NIDX_PORT_W-1:0]  nidx;
        logic [FIDX_PORT_W-1:0]  fidx;
        logic [DATA_WIDTH-1:0]   value;
    } cmd_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_BIAS,
        B_BIAS_WAIT,
        B_MAC,
        B_STORE,
        B_EXP1,
        B_EXP2,
        B_EXP3,
        B_DIV,
        B_ACT,
        B_EMIT
    } bstate_t;

    // exp(-i) in Q1.16
    function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] i);
        logic [EXP_W-1:0] r;
        case (i)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // exp(-h/16) in Q1.16
    function automatic logic [EXP_W-1:0] exp_frac(input logic [3:0] h);
        logic [EXP_W-1:0] r;
        case (h)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd61565;
            4'd2:    r = 17'd57835;
            4'd3:    r = 17'd54331;
            4'd4:    r = 17'd51039;
            4'd5:    r = 17'd47947;
            4'd6:    r = 17'd45042;
            4'd7:    r = 17'd42313;
            4'd8:    r = 17'd39750;
            4'd9:    r = 17'd37341;
            4'd10:   r = 17'd35079;
            4'd11:   r = 17'd32954;
            4'd12:   r = 17'd30957;
            4'd13:   r = 17'd29081;
            4'd14:   r = 17'd27319;
            default: r = 17'd25664;
        endcase
        return r;
    endfunction

endpackage

>>> sv/dlf_ram.sv
module dlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> sv/dlf_div.sv
module dlf_div import dlf_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [SUM_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [SUM_W:0]   trial;
    logic             ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, q_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = den;
            q_next    = num;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? SUM_W'(trial - {1'b0, den_reg}) : SUM_W'(trial);
            q_next   = {q_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

>>> sv/dlf_front.sv
module dlf_front import dlf_pkg::*; #(
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_NEURONS = DEF_MAX_NEURONS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             mode,
    input  logic [NIDX_PORT_W-1:0] neuron_index,
    input  logic [FIDX_PORT_W-1:0] feature_index,
    input  logic [DATA_WIDTH-1:0]  value,
    input  logic                   last_feature,
    output logic                   q_valid,
    input  logic                   q_ready,
    output cmd_t                   q_cmd
);

    cmd_t       cmd;
    logic       keep;
    logic       n_ok;
    logic       f_ok;
    logic       push;
    logic       pop;
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    // classify: drop unused modes and out-of-range loads
    always_comb
    begin
        n_ok       = 32'(neuron_index) < MAX_NEURONS;
        f_ok       = 32'(feature_index) < MAX_INPUTS;
        cmd.nidx   = neuron_index;
        cmd.fidx   = feature_index;
        cmd.value  = value;
        cmd.op     = OP_FEATURE;
        cmd.wr     = 1'b0;
        cmd.last   = 1'b0;
        keep       = 1'b0;
        unique case (mode)
            MODE_WEIGHT:
            begin
                cmd.op = OP_WEIGHT;
                cmd.wr = 1'b1;
                keep   = n_ok && f_ok;
            end
            MODE_BIAS:
            begin
                cmd.op = OP_BIAS;
                cmd.wr = 1'b1;
                keep   = n_ok;
            end
            MODE_FEATURE:
            begin
                cmd.op   = OP_FEATURE;
                cmd.wr   = f_ok;
                cmd.last = last_feature;
                keep     = f_ok || last_feature;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // two-entry queue toward the back end
    assign in_stall = cnt_reg == 2'd2;
    assign push     = in_valid && !in_stall && keep;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_cmd    = slot_reg[rd_ptr_reg];
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

>>> sv/dlf_back.sv
module dlf_back import dlf_pkg::*; #(
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_NEURONS = DEF_MAX_NEURONS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  cmd_t                          q_cmd,
    input  act_t                          act_kind,
    input  logic [CFG_W-1:0]              input_count,
    input  logic [4:0]                    neuron_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [NIDX_PORT_W-1:0]        out_neuron,
    output logic signed [DATA_WIDTH-1:0]  out_value,
    output logic [NIDX_PORT_W-1:0]        best_class,
    output logic                          last_output
);

    localparam int NIDX_W = MAX_NEURONS > 1 ? $clog2(MAX_NEURONS) : 1;
    localparam int NCNT_W = $clog2(MAX_NEURONS + 1);
    localparam int FIDX_W = MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1;
    localparam int FCNT_W = $clog2(MAX_INPUTS + 1);
    localparam int WDEPTH = MAX_NEURONS * MAX_INPUTS;
    localparam int WA_W   = WDEPTH > 1 ? $clog2(WDEPTH) : 1;

    bstate_t state_reg, state_next;

    logic [FCNT_W-1:0] ni;
    logic [NCNT_W-1:0] nn;

    logic              pop;
    logic              w_we, b_we, f_we;
    logic [WA_W-1:0]   w_waddr, w_raddr;
    logic [FIDX_W-1:0] f_waddr, f_raddr;
    logic [NIDX_W-1:0] b_waddr;
    logic [DATA_WIDTH-1:0] w_rd, f_rd, b_rd;

    logic [NIDX_W-1:0]  n_reg, n_next;
    logic [WA_W-1:0]    base_reg, base_next;
    logic [FCNT_W-1:0]  f_reg, f_next;
    logic               rd_v_reg, rd_v_next;
    logic               prod_v_reg, prod_v_next;
    logic signed [31:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [DATA_WIDTH-1:0] mx_reg, mx_next;
    logic [NIDX_W-1:0]  k_reg, k_next;
    logic               pass_reg, pass_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [EXP_W-1:0]   ex_r1_reg, ex_r1_next;
    logic [3:0]         ex_l_reg, ex_l_next;
    logic               ex_big_reg, ex_big_next;
    logic [EXP_W-1:0]   e_reg, e_next;
    logic signed [DATA_WIDTH-1:0] o_reg, o_next;
    logic signed [DATA_WIDTH-1:0] best_val_reg, best_val_next;
    logic [NIDX_W-1:0]  best_idx_reg, best_idx_next;
    logic signed [DATA_WIDTH-1:0] p_arr_reg [MAX_NEURONS];
    logic signed [DATA_WIDTH-1:0] o_arr_reg [MAX_NEURONS];

    logic               out_valid_reg, out_valid_next;
    logic [NIDX_PORT_W-1:0] out_neuron_reg, out_neuron_next;
    logic signed [DATA_WIDTH-1:0] out_value_reg, out_value_next;
    logic [NIDX_PORT_W-1:0] best_class_reg, best_class_next;
    logic               last_reg, last_next;

    logic               issue;
    logic               n_last, k_last, out_free;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W:0]   acc_rnd;
    logic signed [ACC_W-8:0] p_wide;
    logic signed [DATA_WIDTH-1:0] p_new;
    logic signed [DATA_WIDTH-1:0] p_k;
    logic signed [EXP_W-1:0] m_s;
    logic [EXP_W-1:0]   m;
    logic [33:0]        ex_prod1, ex_prod2;
    logic [EXP_W:0]     d_sig;
    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_num, div_quo;
    logic [SUM_W-1:0]   div_den;
    logic               use_div;

    // count registers clamp to 1..max
    always_comb
    begin
        if (input_count == '0)
            ni = FCNT_W'(1);
        else if (32'(input_count) > MAX_INPUTS)
            ni = FCNT_W'(MAX_INPUTS);
        else
            ni = FCNT_W'(input_count);
        if (neuron_count == '0)
            nn = NCNT_W'(1);
        else if (32'(neuron_count) > MAX_NEURONS)
            nn = NCNT_W'(MAX_NEURONS);
        else
            nn = NCNT_W'(neuron_count);
    end

    // store writes come straight from the queue
    assign q_ready = state_reg == B_IDLE;
    assign pop     = q_valid && q_ready;
    assign w_we    = pop && q_cmd.op == OP_WEIGHT;
    assign b_we    = pop && q_cmd.op == OP_BIAS;
    assign f_we    = pop && q_cmd.op == OP_FEATURE && q_cmd.wr;
    assign w_waddr = WA_W'(32'(q_cmd.nidx) * MAX_INPUTS + 32'(q_cmd.fidx));
    assign f_waddr = FIDX_W'(q_cmd.fidx);
    assign b_waddr = NIDX_W'(q_cmd.nidx);
    assign w_raddr = WA_W'(32'(base_reg) + 32'(f_reg));
    assign f_raddr = FIDX_W'(f_reg);

    dlf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(WDEPTH)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (q_cmd.value),
        .raddr (w_raddr),
        .rdata (w_rd)
    );

    dlf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_INPUTS)) u_feature_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (q_cmd.value),
        .raddr (f_raddr),
        .rdata (f_rd)
    );

    dlf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_NEURONS)) u_bias_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (q_cmd.value),
        .raddr (n_reg),
        .rdata (b_rd)
    );

    dlf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign issue    = state_reg == B_MAC && f_reg < ni;
    assign n_last   = NCNT_W'(n_reg) + NCNT_W'(1) == nn;
    assign k_last   = NCNT_W'(k_reg) + NCNT_W'(1) == nn;
    assign out_free = !out_valid_reg || !out_stall;
    assign use_div  = act_kind == ACT_SIGMOID || act_kind == ACT_SOFTMAX;
    assign p_k      = p_arr_reg[k_reg];

    // saturating accumulate and rounding to q8.8
    always_comb
    begin
        acc_sum = {acc_reg[ACC_W-1], acc_reg} + {{(ACC_W-31){prod_reg[31]}}, prod_reg};
        acc_rnd = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(128);
        p_wide  = acc_rnd[ACC_W:8];
        if (p_wide[ACC_W-8:DATA_WIDTH-1] == '0 || p_wide[ACC_W-8:DATA_WIDTH-1] == '1)
            p_new = p_wide[DATA_WIDTH-1:0];
        else if (p_wide[ACC_W-8])
            p_new = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        else
            p_new = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end

    // exp(-m) argument and its two multiply stages
    always_comb
    begin
        if (act_kind == ACT_SOFTMAX)
            m_s = {mx_reg[DATA_WIDTH-1], mx_reg} - {p_k[DATA_WIDTH-1], p_k};
        else if (p_k < 0)
            m_s = EXP_W'(0) - {p_k[DATA_WIDTH-1], p_k};
        else
            m_s = {p_k[DATA_WIDTH-1], p_k};
        m        = m_s;
        ex_prod1 = 34'(exp_int(m[11:8])) * 34'(exp_frac(m[7:4])) + 34'd32768;
        ex_prod2 = 34'(ex_r1_reg) * 34'(17'd65536 - {5'd0, ex_l_reg, 8'd0}) + 34'd32768;
        d_sig    = (EXP_W+1)'(65536) + (EXP_W+1)'(e_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:      if (pop && q_cmd.op == OP_FEATURE && q_cmd.last) state_next = B_BIAS;
            B_BIAS:      state_next = B_BIAS_WAIT;
            B_BIAS_WAIT: state_next = B_MAC;
            B_MAC:       if (!issue && !rd_v_reg && !prod_v_reg) state_next = B_STORE;
            B_STORE:     state_next = n_last ? B_EXP1 : B_BIAS;
            B_EXP1:      state_next = B_EXP2;
            B_EXP2:      state_next = B_EXP3;
            B_EXP3:
            begin
                if (!pass_reg)
                    state_next = B_EXP1;
                else if (use_div)
                    state_next = B_DIV;
                else
                    state_next = B_ACT;
            end
            B_DIV:       if (div_done) state_next = B_ACT;
            B_ACT:       state_next = k_last ? B_EMIT : B_EXP1;
            B_EMIT:      if (out_free && k_last) state_next = B_IDLE;
            default:     state_next = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        n_next          = n_reg;
        base_next       = base_reg;
        f_next          = f_reg;
        rd_v_next       = issue;
        prod_v_next     = rd_v_reg;
        prod_next       = $signed(w_rd) * $signed(f_rd);
        acc_next        = acc_reg;
        mx_next         = mx_reg;
        k_next          = k_reg;
        pass_next       = pass_reg;
        sum_next        = sum_reg;
        ex_r1_next      = ex_prod1[32:16];
        ex_l_next       = m[3:0];
        ex_big_next     = m[EXP_W-1:12] != '0;
        e_next          = ex_big_reg ? '0 : ex_prod2[32:16];
        o_next          = o_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        div_start       = 1'b0;
        div_num         = '0;
        div_den         = '0;
        out_valid_next  = out_valid_reg && out_stall;
        out_neuron_next = out_neuron_reg;
        out_value_next  = out_value_reg;
        best_class_next = best_class_reg;
        last_next       = last_reg;

        if (prod_v_reg)
        begin
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                          : {1'b0, {(ACC_W-1){1'b1}}};
            else
                acc_next = acc_sum[ACC_W-1:0];
        end

        case (state_reg)
            B_IDLE:
            begin
                n_next    = '0;
                base_next = '0;
            end
            B_BIAS_WAIT:
            begin
                acc_next = {{(ACC_W-DATA_WIDTH-8){b_rd[DATA_WIDTH-1]}}, b_rd, 8'd0};
                f_next   = '0;
            end
            B_MAC:
            begin
                if (issue)
                    f_next = f_reg + FCNT_W'(1);
            end
            B_STORE:
            begin
                if (n_reg == '0 || p_new > mx_reg)
                    mx_next = p_new;
                n_next    = n_reg + NIDX_W'(1);
                base_next = WA_W'(32'(base_reg) + MAX_INPUTS);
                k_next    = '0;
                pass_next = act_kind != ACT_SOFTMAX;
                sum_next  = '0;
            end
            B_EXP3:
            begin
                if (!pass_reg)
                begin
                    sum_next = sum_reg + SUM_W'(e_reg);
                    if (k_last)
                    begin
                        k_next    = '0;
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        k_next = k_reg + NIDX_W'(1);
                    end
                end
                else if (act_kind == ACT_SIGMOID)
                begin
                    div_start = 1'b1;
                    div_den   = SUM_W'(d_sig);
                    if (p_k < 0)
                        div_num = NUM_W'({e_reg, 8'd0}) + NUM_W'(d_sig >> 1);
                    else
                        div_num = NUM_W'(1 << 24) + NUM_W'(d_sig >> 1);
                end
                else if (act_kind == ACT_SOFTMAX)
                begin
                    div_start = 1'b1;
                    div_den   = sum_reg;
                    div_num   = NUM_W'({e_reg, 8'd0}) + NUM_W'(sum_reg >> 1);
                end
                else if (act_kind == ACT_RELU && p_k < 0)
                begin
                    o_next = '0;
                end
                else
                begin
                    o_next = p_k;
                end
            end
            B_DIV:
            begin
                if (div_done)
                    o_next = div_quo[DATA_WIDTH-1:0];
            end
            B_ACT:
            begin
                if (k_reg == '0 || o_reg > best_val_reg)
                begin
                    best_val_next = o_reg;
                    best_idx_next = k_reg;
                end
                k_next = k_last ? '0 : k_reg + NIDX_W'(1);
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_neuron_next = NIDX_PORT_W'(k_reg);
                    out_value_next  = o_arr_reg[k_reg];
                    last_next       = k_last;
                    best_class_next = k_last ? NIDX_PORT_W'(best_idx_reg) : '0;
                    k_next          = k_reg + NIDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            n_reg         <= '0;
            f_reg         <= '0;
            k_reg         <= '0;
            pass_reg      <= 1'b0;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            f_reg         <= f_next;
            k_reg         <= k_next;
            pass_reg      <= pass_next;
            rd_v_reg      <= rd_v_next;
            prod_v_reg    <= prod_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        mx_reg         <= mx_next;
        sum_reg        <= sum_next;
        ex_r1_reg      <= ex_r1_next;
        ex_l_reg       <= ex_l_next;
        ex_big_reg     <= ex_big_next;
        e_reg          <= e_next;
        o_reg          <= o_next;
        best_val_reg   <= best_val_next;
        best_idx_reg   <= best_idx_next;
        out_neuron_reg <= out_neuron_next;
        out_value_reg  <= out_value_next;
        best_class_reg <= best_class_next;
        last_reg       <= last_next;
        if (state_reg == B_STORE)
            p_arr_reg[n_reg] <= p_new;
        if (state_reg == B_ACT)
            o_arr_reg[k_reg] <= o_reg;
    end

    assign out_valid   = out_valid_reg;
    assign out_neuron  = out_neuron_reg;
    assign out_value   = out_value_reg;
    assign best_class  = best_class_reg;
    assign last_output = last_reg;

endmodule

>>> sv/dense_layer_forward.sv
// dense layer, signed q8.8: weight and bias beats load the stores, feature beats fill
// the feature buffer, and the feature beat flagged last starts evaluation. a load beat
// passes through a two-entry queue, so the input side keeps accepting while a load is
// written. evaluation uses one multiplier fed by the weight and feature memories, one
// product per cycle, for the sums; then for softmax an exp pass over all neurons builds
// the sum, then each neuron goes through the exp stages and, for sigmoid and softmax,
// the iterative divider, then result beats go out one per cycle while out_stall is low.
// no input beat is taken from the queue while evaluation runs.
// configuration writes are meant for when the block is idle.
module dense_layer_forward import dlf_pkg::*; #(
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_NEURONS = DEF_MAX_NEURONS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    mode,
    input  logic [NIDX_PORT_W-1:0]        neuron_index,
    input  logic [FIDX_PORT_W-1:0]        feature_index,
    input  logic signed [DATA_WIDTH-1:0]  value,
    input  logic                          last_feature,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [NIDX_PORT_W-1:0]        out_neuron,
    output logic signed [DATA_WIDTH-1:0]  out_value,
    output logic [NIDX_PORT_W-1:0]        best_class,
    output logic                          last_output
);

    act_t             act_reg, act_next;
    logic [CFG_W-1:0] inputs_reg, inputs_next;
    logic [4:0]       neurons_reg, neurons_next;
    logic             q_valid;
    logic             q_ready;
    cmd_t             q_cmd;

    // configuration registers, indexes beyond the list are dropped
    always_comb
    begin
        act_next     = act_reg;
        inputs_next  = inputs_reg;
        neurons_next = neurons_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACT:     act_next     = act_t'(cfg_data[1:0]);
                REG_INPUTS:  inputs_next  = cfg_data;
                REG_NEURONS: neurons_next = cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg     <= ACT_NONE;
            inputs_reg  <= CFG_W'(64);
            neurons_reg <= 5'd16;
        end
        else
        begin
            act_reg     <= act_next;
            inputs_reg  <= inputs_next;
            neurons_reg <= neurons_next;
        end
    end

    // front end: classifies beats and queues them
    dlf_front #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_NEURONS (MAX_NEURONS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .neuron_index  (neuron_index),
        .feature_index (feature_index),
        .value         (value),
        .last_feature  (last_feature),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd)
    );

    // back end: stores, multiply-accumulate, activation and result beats
    dlf_back #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_NEURONS (MAX_NEURONS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd),
        .act_kind     (act_reg),
        .input_count  (inputs_reg),
        .neuron_count (neurons_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_neuron   (out_neuron),
        .out_value    (out_value),
        .best_class   (best_class),
        .last_output  (last_output)
    );

endmodule

>>> sv/dlf_check.sv
module dlf_check import dlf_pkg::*; (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [NIDX_PORT_W-1:0]        out_neuron,
    input logic signed [DATA_WIDTH-1:0]  out_value,
    input logic [NIDX_PORT_W-1:0]        best_class,
    input logic                          last_output
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_neuron))
        else $error("result beat changed while stalled");

    // best class only on the final beat
    a_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_output |-> best_class == '0)
        else $error("best class set on a non-final beat");

    // result beats of one sample follow back to back in neuron order
    a_next_neuron: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_output |=>
            out_valid && out_neuron == $past(out_neuron) + NIDX_PORT_W'(1))
        else $error("result beats out of order");

endmodule

bind dense_layer_forward dlf_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_neuron  (out_neuron),
    .out_value   (out_value),
    .best_class  (best_class),
    .last_output (last_output)
);

>>> bench/dense_layer_forward_test.sv
module dense_layer_forward_test;
    import dlf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run limits, in clock cycles
    localparam int QUIET_LIMIT = 8000;   // cycles with no beat on any channel
    localparam int LOAD_DRAIN  = 20;     // load queue settling before a register write
    localparam int TAIL_WAIT   = 60;     // after the last result beat
    localparam int HOLD_CYCLES = 600;    // long result-side hold-off
    localparam int ITEM_GOAL   = 370;
    localparam int RESULT_GOAL = 60;

    // codes the package leaves unnamed
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] REG_NONE    = 2'd3;

    localparam longint SUM_HI = (longint'(1) <<< 39) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;

    // exp(-i) and exp(-h/16) in q1.16
    localparam longint EXP_WHOLE[16] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                         22, 8, 3, 1, 0, 0, 0, 0};
    localparam longint EXP_NIBBLE[16] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                          45042, 42313, 39750, 37341, 35079, 32954,
                                          30957, 29081, 27319, 25664};

    typedef struct {
        logic [3:0]         nrn;
        logic signed [15:0] val;
        logic [3:0]         best;
        logic               lst;
    } neuron_out_t;

    // one directed row: a register write or an input beat, with typed outputs
    // for the two neurons where they are plain to see
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [6:0]  reg_val;
        logic [1:0]  md;
        logic [3:0]  n;
        logic [5:0]  f;
        logic [15:0] v;
        logic        lst;
        bit          typed;
        logic [15:0] out0;
        logic [15:0] out1;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [1:0]             cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             mode;
    logic [NIDX_PORT_W-1:0] neuron_index;
    logic [FIDX_PORT_W-1:0] feature_index;
    logic signed [15:0]     value;
    logic                   last_feature;
    logic                   out_valid;
    logic                   out_stall;
    logic [NIDX_PORT_W-1:0] out_neuron;
    logic signed [15:0]     out_value;
    logic [NIDX_PORT_W-1:0] best_class;
    logic                   last_output;

    dense_layer_forward uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .neuron_index(neuron_index), .feature_index(feature_index),
        .value(value), .last_feature(last_feature),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_neuron(out_neuron), .out_value(out_value),
        .best_class(best_class), .last_output(last_output)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // layer copy kept by the bench
    logic [1:0]  act_sel;
    logic [6:0]  in_cnt;
    logic [4:0]  nrn_cnt;
    longint      weights [16][64];
    longint      biases [16];
    longint      features [64];
    bit          weight_set [16][64];
    bit          bias_set [16];

    neuron_out_t pending_outputs[$];
    int          errors;
    int          items_sent;
    int          results_seen;
    int          quiet_cycles;
    bit          calm;
    bit          hold_req;
    directed_row_t rows[$];

    function automatic int clamp_count(int raw, int top);
        if (raw == 0)
            return 1;
        return (raw > top) ? top : raw;
    endfunction

    // e^-m for q8.8 m >= 0, in q1.16
    function automatic longint neg_exp(longint m);
        longint r;
        if (m >= 4096)
            return 0;
        r = (EXP_WHOLE[(m >> 8) & 15] * EXP_NIBBLE[(m >> 4) & 15] + 32768) >> 16;
        return (r * (65536 - 256 * (m & 15)) + 32768) >> 16;
    endfunction

    function automatic longint sigmoid_q88(longint p);
        longint e;
        longint d;
        e = neg_exp(p >= 0 ? p : -p);
        d = 65536 + e;
        if (p >= 0)
            return ((longint'(1) <<< 24) + d / 2) / d;
        return (e * 256 + d / 2) / d;
    endfunction

    // applies one accepted beat to the layer copy, queues the neuron outputs it causes
    function automatic void layer_predict(logic [1:0] md, logic [3:0] n, logic [5:0] f,
                                          logic signed [15:0] v, logic lst);
        longint      acc;
        longint      mx;
        longint      tot;
        longint      pre [16];
        longint      act [16];
        longint      ex [16];
        int          ni;
        int          nn;
        int          best;
        neuron_out_t r;
        if (md == MODE_WEIGHT)
        begin
            weights[n][f] = v;
            weight_set[n][f] = 1'b1;
            return;
        end
        if (md == MODE_BIAS)
        begin
            biases[n] = v;
            bias_set[n] = 1'b1;
            return;
        end
        if (md != MODE_FEATURE)
            return;
        features[f] = v;
        if (!lst)
            return;
        ni = clamp_count(in_cnt, 64);
        nn = clamp_count(nrn_cnt, 16);
        for (int k = 0; k < nn; k++)
        begin
            acc = biases[k] * 256;
            for (int j = 0; j < ni; j++)
            begin
                acc = acc + weights[k][j] * features[j];
                if (acc > SUM_HI)
                    acc = SUM_HI;
                else if (acc < SUM_LO)
                    acc = SUM_LO;
            end
            acc = (acc + 128) >>> 8;
            pre[k] = (acc > 32767) ? 32767 : ((acc < -32768) ? -32768 : acc);
        end
        if (act_sel == ACT_SOFTMAX)
        begin
            mx = pre[0];
            tot = 0;
            for (int k = 1; k < nn; k++)
                if (pre[k] > mx)
                    mx = pre[k];
            for (int k = 0; k < nn; k++)
            begin
                ex[k] = neg_exp(mx - pre[k]);
                tot += ex[k];
            end
            for (int k = 0; k < nn; k++)
                act[k] = (ex[k] * 256 + tot / 2) / tot;
        end
        else
        begin
            for (int k = 0; k < nn; k++)
            begin
                if (act_sel == ACT_RELU)
                    act[k] = (pre[k] < 0) ? 0 : pre[k];
                else if (act_sel == ACT_SIGMOID)
                    act[k] = sigmoid_q88(pre[k]);
                else
                    act[k] = pre[k];
            end
        end
        best = 0;
        for (int k = 1; k < nn; k++)
            if (act[k] > act[best])
                best = k;
        for (int k = 0; k < nn; k++)
        begin
            r.nrn  = k;
            r.val  = act[k];
            r.lst  = (k == nn - 1);
            r.best = r.lst ? best : 0;
            pending_outputs.push_back(r);
        end
    endfunction

    task automatic report(string field, longint want, longint got);
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        errors++;
    endtask

    // one input beat: optional gap, then hold until taken
    task automatic send_beat(logic [1:0] md, logic [3:0] n, logic [5:0] f,
                             logic [15:0] v, logic lst);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode          <= md;
        neuron_index  <= n;
        feature_index <= f;
        value         <= v;
        last_feature  <= lst;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        layer_predict(md, n, f, v, lst);
        if (md != MODE_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // drop valid, let every queued output drain, then let pending loads settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
        repeat (LOAD_DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ACT)
            act_sel = data[1:0];
        else if (idx == REG_INPUTS)
            in_cnt = data;
        else if (idx == REG_NEURONS)
            nrn_cnt = data[4:0];
    endtask

    function automatic logic [15:0] rand_word();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 1023) - 512;
    endfunction

    // one sample: fill whatever the evaluation will read, refresh some entries,
    // sprinkle noise, then all features in shuffled order with the last one flagged
    task automatic run_sample(int ni, int nn);
        int order [64];
        int j;
        int t;
        for (int k = 0; k < nn; k++)
        begin
            if (!bias_set[k] || $urandom_range(0, 3) == 0)
                send_beat(MODE_BIAS, k, $urandom, rand_word(), $urandom);
            for (int q = 0; q < ni; q++)
                if (!weight_set[k][q] || $urandom_range(0, 5) == 0)
                    send_beat(MODE_WEIGHT, k, q, rand_word(), $urandom);
        end
        if ($urandom_range(0, 2) == 0)
            send_beat(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom);
        // a feature beyond the count in use, never flagged last
        if (ni < 64 && $urandom_range(0, 2) == 0)
            send_beat(MODE_FEATURE, $urandom, $urandom_range(ni, 63), rand_word(), 1'b0);
        for (int q = 0; q < ni; q++)
            order[q] = q;
        for (int q = ni - 1; q > 0; q--)
        begin
            j = $urandom_range(0, q);
            t = order[q];
            order[q] = order[j];
            order[j] = t;
        end
        for (int q = 0; q < ni; q++)
            send_beat(MODE_FEATURE, $urandom, order[q], rand_word(), q == ni - 1);
    endtask

    // result side: random stall before each beat, one long hold-off on request
    initial
    begin
        int w;
        out_stall = 1'b1;
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                w = calm ? 0 : $urandom_range(0, 10);
                if (w > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (w) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall) && !hold_req);
            @(negedge clk);
        end
    end

    // compare each result beat against the oldest queued output
    always @(posedge clk)
    begin
        neuron_out_t r;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_outputs.size() == 0)
                report("unexpected result beat, neuron", -1, out_neuron);
            else
            begin
                r = pending_outputs.pop_front();
                if (out_neuron !== r.nrn)
                    report("out_neuron", r.nrn, out_neuron);
                if (out_value !== r.val)
                    report("out_value", r.val, out_value);
                if (best_class !== r.best)
                    report("best_class", r.best, best_class);
                if (last_output !== r.lst)
                    report("last_output", r.lst, last_output);
            end
        end
    end

    // watchdog on cycles with no beat anywhere
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int ni;
        int nn;
        int ni_raw;
        int nn_raw;
        int phase;
        bit held;
        logic [6:0] ni_pick [8];
        logic [4:0] nn_pick [7];
        neuron_out_t r;
        ni_pick = '{0, 1, 2, 3, 5, 8, 64, 127};
        nn_pick = '{0, 1, 2, 4, 7, 16, 31};

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ACT;
        cfg_data      = '0;
        in_valid      = 1'b0;
        mode          = MODE_WEIGHT;
        neuron_index  = '0;
        feature_index = '0;
        value         = '0;
        last_feature  = 1'b0;
        errors        = 0;
        items_sent    = 0;
        results_seen  = 0;
        quiet_cycles  = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        held          = 1'b0;
        act_sel       = ACT_NONE;
        in_cnt        = 64;
        nrn_cnt       = 16;
        for (int k = 0; k < 16; k++)
        begin
            bias_set[k] = 1'b0;
            for (int q = 0; q < 64; q++)
                weight_set[k][q] = 1'b0;
        end

        // directed rows: one feature, two neurons driven to the rails
        // neuron 0: 1.0 bias, max weight; neuron 1: min bias, min weight
        rows.push_back('{1, REG_ACT, ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{1, REG_INPUTS, 1, 0, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{1, REG_NEURONS, 2, 0, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{0, 0, 0, MODE_BIAS, 0, 0, 16'h0100, 0, 0, 0, 0});
        // last flag on a load does nothing
        rows.push_back('{0, 0, 0, MODE_BIAS, 1, 63, 16'h8000, 1, 0, 0, 0});
        rows.push_back('{0, 0, 0, MODE_WEIGHT, 0, 0, 16'h7fff, 0, 0, 0, 0});
        rows.push_back('{0, 0, 0, MODE_WEIGHT, 1, 0, 16'h8000, 1, 0, 0, 0});
        // unused mode is dropped, no output
        rows.push_back('{0, 0, 0, MODE_UNUSED, 15, 63, 16'hffff, 1, 0, 0, 0});
        // both sums saturate: +max and -min
        rows.push_back('{0, 0, 0, MODE_FEATURE, 0, 0, 16'h7fff, 1, 1, 16'h7fff, 16'h8000});
        rows.push_back('{1, REG_ACT, ACT_RELU, 0, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{0, 0, 0, MODE_FEATURE, 9, 0, 16'h7fff, 1, 1, 16'h7fff, 16'h0000});
        rows.push_back('{1, REG_ACT, ACT_SIGMOID, 0, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{0, 0, 0, MODE_FEATURE, 0, 0, 16'h7fff, 1, 1, 16'h0100, 16'h0000});
        rows.push_back('{1, REG_ACT, ACT_SOFTMAX, 0, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{0, 0, 0, MODE_FEATURE, 0, 0, 16'h7fff, 1, 1, 16'h0100, 16'h0000});
        rows.push_back('{0, 0, 0, MODE_FEATURE, 0, 0, 16'h0000, 1, 0, 0, 0});
        // write to a nonexistent register is dropped
        rows.push_back('{1, REG_NONE, 7'h55, 0, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{0, 0, 0, MODE_FEATURE, 0, 0, 16'hffff, 1, 0, 0, 0});
        rows.push_back('{1, REG_ACT, ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0});
        rows.push_back('{0, 0, 0, MODE_FEATURE, 0, 0, 16'hffff, 1, 0, 0, 0});

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            else
            begin
                send_beat(rows[i].md, rows[i].n, rows[i].f, rows[i].v, rows[i].lst);
                // swap in the hand-computed values for the two neurons
                if (rows[i].typed)
                begin
                    r = pending_outputs[pending_outputs.size() - 2];
                    r.val = rows[i].out0;
                    pending_outputs[pending_outputs.size() - 2] = r;
                    r = pending_outputs[pending_outputs.size() - 1];
                    r.val = rows[i].out1;
                    pending_outputs[pending_outputs.size() - 1] = r;
                end
            end
        end

        // phases; the first three pin the count extremes, the next two are fixed, later ones random
        phase = 0;
        while (items_sent < ITEM_GOAL || results_seen < RESULT_GOAL)
        begin
            case (phase)
                0:       begin ni_raw = 127; nn_raw = 1; end
                1:       begin ni_raw = 1;   nn_raw = 31; end
                2:       begin ni_raw = 0;   nn_raw = 0; end
                3:       begin ni_raw = 64;  nn_raw = 2; end
                4:       begin ni_raw = 2;   nn_raw = 16; end
                default:
                begin
                    ni_raw = ni_pick[$urandom_range(0, 7)];
                    nn_raw = nn_pick[$urandom_range(0, 6)];
                end
            endcase
            ni = clamp_count(ni_raw, 64);
            nn = clamp_count(nn_raw, 16);
            // keep the big sizes rare: wide inputs only with few neurons
            if (ni * nn > 128)
            begin
                nn_raw = $urandom_range(1, 2);
                nn = nn_raw;
            end
            write_reg(REG_ACT, (phase < 4) ? phase : $urandom_range(0, 3));
            write_reg(REG_INPUTS, ni_raw);
            write_reg(REG_NEURONS, nn_raw);
            for (int s = 0; s < 3; s++)
            begin
                calm = ($urandom_range(0, 4) == 0);
                // once: hold the result side so the block backs up onto its input
                if (!held && phase == 6 && s == 0)
                begin
                    hold_req = 1'b1;
                    held = 1'b1;
                    calm = 1'b1;
                end
                run_sample(ni, nn);
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);

        if (errors == 0 && pending_outputs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
